// ===== rtl/pcp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and constants of the path command pruner: command and record
// codes, the command word, the record word and the contour flags.
// ----------------------------------------------------------------------------
package pcp_pkg;

  // coordinate width of the contour state
  localparam int unsigned CoordBits = 32;

  // conic weights that need special handling, Q16.16
  localparam logic [31:0] WeightOne  = 32'h0001_0000;
  localparam logic [31:0] WeightZero = 32'h0000_0000;

  // incoming command codes, code 7 is undefined
  typedef enum logic [2:0] {
    REQ_MOVE     = 3'd0,
    REQ_LINE     = 3'd1,
    REQ_QUAD     = 3'd2,
    REQ_CONIC    = 3'd3,
    REQ_CUBIC    = 3'd4,
    REQ_CLOSE    = 3'd5,
    REQ_PATH_END = 3'd6
  } req_e;

  // outgoing record kinds
  typedef enum logic [2:0] {
    KIND_BEGIN = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_QUAD  = 3'd2,
    KIND_CONIC = 3'd3,
    KIND_CUBIC = 3'd4,
    KIND_END   = 3'd5
  } kind_e;

  // one command as taken from the input channel
  typedef struct packed {
    logic [2:0]  req_type;
    logic        will_close;
    logic [31:0] pt_a_x;
    logic [31:0] pt_a_y;
    logic [31:0] pt_b_x;
    logic [31:0] pt_b_y;
    logic [31:0] pt_c_x;
    logic [31:0] pt_c_y;
    logic [31:0] conic_weight;
  } cmd_t;

  // one segment record as shown on the output channel
  typedef struct packed {
    kind_e       kind;
    logic [31:0] p0_x;
    logic [31:0] p0_y;
    logic [31:0] p1_x;
    logic [31:0] p1_y;
    logic [31:0] p2_x;
    logic [31:0] p2_y;
    logic [31:0] p3_x;
    logic [31:0] p3_y;
    logic [31:0] seg_weight;
    logic        close_flag;
  } rec_t;

  // contour flags
  typedef struct packed {
    logic has_segments;
    logic has_points;
    logic pending_close;
  } flags_t;

endpackage

// ===== rtl/pcp_seg_gen.sv =====
// ----------------------------------------------------------------------------
// pcp_seg_gen
// Decodes one command against the contour state: builds the begin marker,
// the segment and the end marker slots with their enables, and the state
// the contour takes once the command is done.
// ----------------------------------------------------------------------------
module pcp_seg_gen #(
  parameter int unsigned COORD_BITS = pcp_pkg::CoordBits
) (
  input  logic                  stroke_mode_i,
  input  pcp_pkg::cmd_t         cmd_i,
  input  logic [COORD_BITS-1:0] org_x_i,
  input  logic [COORD_BITS-1:0] org_y_i,
  input  logic [COORD_BITS-1:0] cur_x_i,
  input  logic [COORD_BITS-1:0] cur_y_i,
  input  pcp_pkg::flags_t       flags_i,
  output logic [2:0]            en_o,
  output pcp_pkg::rec_t         rec_begin_o,
  output pcp_pkg::rec_t         rec_seg_o,
  output pcp_pkg::rec_t         rec_end_o,
  output logic [COORD_BITS-1:0] nxt_org_x_o,
  output logic [COORD_BITS-1:0] nxt_org_y_o,
  output logic [COORD_BITS-1:0] nxt_cur_x_o,
  output logic [COORD_BITS-1:0] nxt_cur_y_o,
  output pcp_pkg::flags_t       nxt_flags_o
);

  // port word to coordinate width
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [31:0] v);
    logic [63:0] t;
    t = {32'b0, v};
    return t[COORD_BITS-1:0];
  endfunction

  // coordinate width to port word
  function automatic logic [31:0] to_port(input logic [COORD_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, ex, ey;
  logic                  a_eq_cur, b_eq_a, b_eq_cur, c_eq_cur, e_eq_cur, cur_eq_org;
  logic                  degen;
  logic                  en_begin, en_seg, en_end;

  assign ax = to_coord(cmd_i.pt_a_x);
  assign ay = to_coord(cmd_i.pt_a_y);
  assign bx = to_coord(cmd_i.pt_b_x);
  assign by = to_coord(cmd_i.pt_b_y);
  assign cx = to_coord(cmd_i.pt_c_x);
  assign cy = to_coord(cmd_i.pt_c_y);

  // end point of a line, quad or conic command
  assign ex = (cmd_i.req_type == pcp_pkg::REQ_LINE) ? ax : bx;
  assign ey = (cmd_i.req_type == pcp_pkg::REQ_LINE) ? ay : by;

  // exact point compares
  assign a_eq_cur   = (ax == cur_x_i) && (ay == cur_y_i);
  assign b_eq_a     = (bx == ax) && (by == ay);
  assign b_eq_cur   = (bx == cur_x_i) && (by == cur_y_i);
  assign c_eq_cur   = (cx == cur_x_i) && (cy == cur_y_i);
  assign e_eq_cur   = (ex == cur_x_i) && (ey == cur_y_i);
  assign cur_eq_org = (cur_x_i == org_x_i) && (cur_y_i == org_y_i);

  // curve that collapses to a line
  always_comb begin
    unique case (cmd_i.req_type)
      pcp_pkg::REQ_QUAD:  degen = a_eq_cur || b_eq_a;
      pcp_pkg::REQ_CONIC: degen = a_eq_cur || b_eq_a ||
                                  ((cmd_i.conic_weight == pcp_pkg::WeightZero) &&
                                   (cmd_i.conic_weight != pcp_pkg::WeightOne));
      default:            degen = 1'b1;
    endcase
  end

  // begin and end markers sit on the contour origin
  always_comb begin
    rec_begin_o            = '0;
    rec_begin_o.kind       = pcp_pkg::KIND_BEGIN;
    rec_begin_o.p0_x       = to_port(org_x_i);
    rec_begin_o.p0_y       = to_port(org_y_i);
    rec_begin_o.close_flag = flags_i.pending_close;
    rec_end_o              = '0;
    rec_end_o.kind         = pcp_pkg::KIND_END;
    rec_end_o.p0_x         = to_port(org_x_i);
    rec_end_o.p0_y         = to_port(org_y_i);
    rec_end_o.close_flag   = (cmd_i.req_type == pcp_pkg::REQ_CLOSE);
  end

  // segment slot, enables and next state per command
  always_comb begin
    en_begin    = 1'b0;
    en_seg      = 1'b0;
    en_end      = 1'b0;
    rec_seg_o   = '0;
    nxt_org_x_o = org_x_i;
    nxt_org_y_o = org_y_i;
    nxt_cur_x_o = cur_x_i;
    nxt_cur_y_o = cur_y_i;
    nxt_flags_o = flags_i;
    // closing line from the current point back to the origin
    rec_seg_o.kind = pcp_pkg::KIND_LINE;
    rec_seg_o.p0_x = to_port(cur_x_i);
    rec_seg_o.p0_y = to_port(cur_y_i);
    rec_seg_o.p1_x = to_port(org_x_i);
    rec_seg_o.p1_y = to_port(org_y_i);
    case (cmd_i.req_type)
      pcp_pkg::REQ_MOVE: begin
        if (stroke_mode_i) begin
          en_seg         = flags_i.has_segments && !flags_i.has_points;
          rec_seg_o.p0_x = to_port(org_x_i);
          rec_seg_o.p0_y = to_port(org_y_i);
        end else begin
          en_seg = !cur_eq_org;
        end
        en_end                    = flags_i.has_segments;
        nxt_org_x_o               = ax;
        nxt_org_y_o               = ay;
        nxt_cur_x_o               = ax;
        nxt_cur_y_o               = ay;
        nxt_flags_o.has_segments  = 1'b0;
        nxt_flags_o.has_points    = 1'b0;
        nxt_flags_o.pending_close = cmd_i.will_close;
      end
      pcp_pkg::REQ_LINE, pcp_pkg::REQ_QUAD, pcp_pkg::REQ_CONIC: begin
        en_begin = !flags_i.has_segments;
        if (degen) begin
          en_seg         = !e_eq_cur;
          rec_seg_o.p1_x = to_port(ex);
          rec_seg_o.p1_y = to_port(ey);
        end else begin
          en_seg         = 1'b1;
          rec_seg_o.p1_x = to_port(ax);
          rec_seg_o.p1_y = to_port(ay);
          rec_seg_o.p2_x = to_port(bx);
          rec_seg_o.p2_y = to_port(by);
          if ((cmd_i.req_type == pcp_pkg::REQ_CONIC) &&
              (cmd_i.conic_weight != pcp_pkg::WeightOne)) begin
            rec_seg_o.kind       = pcp_pkg::KIND_CONIC;
            rec_seg_o.seg_weight = cmd_i.conic_weight;
          end else begin
            rec_seg_o.kind = pcp_pkg::KIND_QUAD;
          end
        end
        nxt_flags_o.has_segments = 1'b1;
        if (en_seg) begin
          nxt_cur_x_o            = ex;
          nxt_cur_y_o            = ey;
          nxt_flags_o.has_points = 1'b1;
        end
      end
      pcp_pkg::REQ_CUBIC: begin
        en_begin       = !flags_i.has_segments;
        en_seg         = !(a_eq_cur && b_eq_cur && c_eq_cur);
        rec_seg_o.kind = pcp_pkg::KIND_CUBIC;
        rec_seg_o.p1_x = to_port(ax);
        rec_seg_o.p1_y = to_port(ay);
        rec_seg_o.p2_x = to_port(bx);
        rec_seg_o.p2_y = to_port(by);
        rec_seg_o.p3_x = to_port(cx);
        rec_seg_o.p3_y = to_port(cy);
        nxt_flags_o.has_segments = 1'b1;
        if (en_seg) begin
          nxt_cur_x_o            = cx;
          nxt_cur_y_o            = cy;
          nxt_flags_o.has_points = 1'b1;
        end
      end
      pcp_pkg::REQ_CLOSE: begin
        en_begin                 = !flags_i.has_segments;
        en_seg                   = stroke_mode_i ? !flags_i.has_points : !cur_eq_org;
        en_end                   = 1'b1;
        nxt_cur_x_o              = org_x_i;
        nxt_cur_y_o              = org_y_i;
        nxt_flags_o.has_segments = 1'b0;
        nxt_flags_o.has_points   = 1'b0;
      end
      pcp_pkg::REQ_PATH_END: begin
        en_seg      = !stroke_mode_i && !cur_eq_org;
        en_end      = flags_i.has_segments;
        nxt_org_x_o = '0;
        nxt_org_y_o = '0;
        nxt_cur_x_o = '0;
        nxt_cur_y_o = '0;
        nxt_flags_o = '0;
      end
      default: begin
        // undefined command: no records, state kept
      end
    endcase
  end

  assign en_o = {en_end, en_seg, en_begin};

endmodule

// ===== rtl/path_command_pruner.sv =====
// ----------------------------------------------------------------------------
// path_command_pruner
// Turns path commands into normalized segment records, pruning duplicate
// points and lowering degenerate curves.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one path command per
//   transfer. Output channel (out_valid_o / out_stall_i) carries one segment
//   record per transfer, last_o marks the final record of a command.
//   cfg_valid_i / cfg_ready_o writes stroke_mode; write only while idle.
//   A command goes to a command register, then each of its records is picked
//   in turn into the output register, one record per cycle while the receiver
//   does not stall. A command with n records (0 to 3) holds the command
//   register until its last record is sent; the single output register port
//   sets the record rate. The first record passes the command register and
//   then the output register. A command with no records makes no output.
//   When the receiver stalls, the output record holds and the command
//   register fills; then in_stall_o rises until records move again.
//   Reset clears the contour state to zero, stroke_mode to fill rules and
//   empties both registers.
// ----------------------------------------------------------------------------
module path_command_pruner #(
  parameter int unsigned COORD_BITS = pcp_pkg::CoordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_stroke_mode_i,
  // command input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic        will_close_i,
  input  logic [31:0] pt_a_x_i,
  input  logic [31:0] pt_a_y_i,
  input  logic [31:0] pt_b_x_i,
  input  logic [31:0] pt_b_y_i,
  input  logic [31:0] pt_c_x_i,
  input  logic [31:0] pt_c_y_i,
  input  logic [31:0] conic_weight_i,
  // record output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [31:0] p0_x_o,
  output logic [31:0] p0_y_o,
  output logic [31:0] p1_x_o,
  output logic [31:0] p1_y_o,
  output logic [31:0] p2_x_o,
  output logic [31:0] p2_y_o,
  output logic [31:0] p3_x_o,
  output logic [31:0] p3_y_o,
  output logic [31:0] seg_weight_o,
  output logic        close_flag_o,
  output logic        last_o
);

  logic                  stroke_mode_q;
  logic                  cmd_vld_q;
  pcp_pkg::cmd_t         cmd_q;
  logic [2:0]            done_q, done_d;
  logic [COORD_BITS-1:0] org_x_q, org_y_q, cur_x_q, cur_y_q;
  pcp_pkg::flags_t       flags_q;
  logic                  out_vld_q;
  pcp_pkg::rec_t         out_q;
  logic                  out_last_q;

  logic [2:0]            en;
  pcp_pkg::rec_t         rec_begin, rec_seg, rec_end, rec_sel;
  logic [COORD_BITS-1:0] nxt_org_x, nxt_org_y, nxt_cur_x, nxt_cur_y;
  pcp_pkg::flags_t       nxt_flags;
  logic [2:0]            remain, sel, rest;
  logic                  out_free, send, retire, in_xfer;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stroke_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stroke_mode_q <= cfg_stroke_mode_i;
    end
  end

  // record builder
  pcp_seg_gen #(
    .COORD_BITS(COORD_BITS)
  ) u_seg_gen (
    .stroke_mode_i(stroke_mode_q),
    .cmd_i        (cmd_q),
    .org_x_i      (org_x_q),
    .org_y_i      (org_y_q),
    .cur_x_i      (cur_x_q),
    .cur_y_i      (cur_y_q),
    .flags_i      (flags_q),
    .en_o         (en),
    .rec_begin_o  (rec_begin),
    .rec_seg_o    (rec_seg),
    .rec_end_o    (rec_end),
    .nxt_org_x_o  (nxt_org_x),
    .nxt_org_y_o  (nxt_org_y),
    .nxt_cur_x_o  (nxt_cur_x),
    .nxt_cur_y_o  (nxt_cur_y),
    .nxt_flags_o  (nxt_flags)
  );

  // pick the first record not yet sent
  assign remain   = en & ~done_q;
  assign sel      = remain & (~remain + 3'd1);
  assign rest     = remain & ~sel;
  assign out_free = !out_vld_q || !out_stall_i;
  assign send     = cmd_vld_q && (remain != 3'b000) && out_free;
  assign retire   = cmd_vld_q && ((remain == 3'b000) || (send && (rest == 3'b000)));
  assign in_stall_o = cmd_vld_q && !retire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    case (sel)
      3'b001:  rec_sel = rec_begin;
      3'b010:  rec_sel = rec_seg;
      default: rec_sel = rec_end;
    endcase
  end

  always_comb begin
    if (retire) begin
      done_d = 3'b000;
    end else if (send) begin
      done_d = done_q | sel;
    end else begin
      done_d = done_q;
    end
  end

  // command register and sent-record mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      done_q    <= 3'b000;
    end else begin
      done_q <= done_d;
      if (in_xfer) begin
        cmd_vld_q <= 1'b1;
      end else if (retire) begin
        cmd_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q.req_type     <= req_type_i;
      cmd_q.will_close   <= will_close_i;
      cmd_q.pt_a_x       <= pt_a_x_i;
      cmd_q.pt_a_y       <= pt_a_y_i;
      cmd_q.pt_b_x       <= pt_b_x_i;
      cmd_q.pt_b_y       <= pt_b_y_i;
      cmd_q.pt_c_x       <= pt_c_x_i;
      cmd_q.pt_c_y       <= pt_c_y_i;
      cmd_q.conic_weight <= conic_weight_i;
    end
  end

  // contour state, updated when a command leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      flags_q <= '0;
    end else if (retire) begin
      org_x_q <= nxt_org_x;
      org_y_q <= nxt_org_y;
      cur_x_q <= nxt_cur_x;
      cur_y_q <= nxt_cur_y;
      flags_q <= nxt_flags;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= send;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send) begin
      out_q      <= rec_sel;
      out_last_q <= (rest == 3'b000);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_kind_o   = out_q.kind;
  assign p0_x_o       = out_q.p0_x;
  assign p0_y_o       = out_q.p0_y;
  assign p1_x_o       = out_q.p1_x;
  assign p1_y_o       = out_q.p1_y;
  assign p2_x_o       = out_q.p2_x;
  assign p2_y_o       = out_q.p2_y;
  assign p3_x_o       = out_q.p3_x;
  assign p3_y_o       = out_q.p3_y;
  assign seg_weight_o = out_q.seg_weight;
  assign close_flag_o = out_q.close_flag;
  assign last_o       = out_last_q;

endmodule
